>>> rtl/core/mmrp_pkg.sv
// ----------------------------------------------------------------------------
// mmrp_pkg: shared types and constants of the meter reply parser
// Holds the frame geometry, CRC constants, register indexes and the result
// record that the frame tracker hands to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package mmrp_pkg;

	// Frame geometry: total length and the span covered by the CRC.
	localparam int unsigned FRAME_LEN = 25;
	localparam int unsigned CRC_SPAN  = 23;

	// CRC-16/MODBUS, reflected form.
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	// Configuration register indexes and reset values.
	localparam logic CFG_SLAVE_ADDR = 1'b0;
	localparam logic CFG_FUNC_CODE  = 1'b1;
	localparam logic [7:0] SLAVE_ADDR_RST = 8'h01;
	localparam logic [7:0] FUNC_CODE_RST  = 8'h04;

	// Request kinds on the input tuser bit.
	localparam logic REQ_BYTE  = 1'b0;
	localparam logic REQ_FLUSH = 1'b1;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_BAD_FUNC = 2'd1,
		ST_BAD_CRC  = 2'd2
	} status_t;

	// One parsed reply.
	typedef struct packed {
		logic [15:0] frequency;
		logic [31:0] power;
		logic [31:0] current;
		logic [15:0] voltage;
		status_t     status;
	} result_t;

endpackage

`default_nettype wire

>>> rtl/core/mmrp_crc_byte.sv
// ----------------------------------------------------------------------------
// mmrp_crc_byte: one-byte CRC-16/MODBUS update
// Folds one byte into a running CRC with the eight shift steps unrolled.
// ----------------------------------------------------------------------------
`default_nettype none

module mmrp_crc_byte (
	input  wire logic [15:0] crc_in,
	input  wire logic [7:0]  data,
	output logic      [15:0] crc_out
);

	// Eight reflected shift-and-xor steps over the low byte.
	always_comb begin
		logic [15:0] c;
		c = crc_in ^ {8'h00, data};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ mmrp_pkg::CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		crc_out = c;
	end

endmodule

`default_nettype wire

>>> rtl/core/mmrp_frame.sv
// ----------------------------------------------------------------------------
// mmrp_frame: frame tracker of the meter reply parser
// Holds the byte count, running CRC and field captures of the open frame and
// builds the result when the last byte of the frame arrives.
// ----------------------------------------------------------------------------
`default_nettype none

module mmrp_frame (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                proc,
	input  wire logic                req_type,
	input  wire logic [7:0]          rx_byte,
	input  wire logic [7:0]          slave_addr,
	input  wire logic [7:0]          func_code,
	output logic                     res_vld,
	output mmrp_pkg::result_t        res
);

	localparam logic [4:0] LAST_POS = 5'(mmrp_pkg::FRAME_LEN - 1);
	localparam logic [4:0] CRC_END  = 5'(mmrp_pkg::CRC_SPAN);

	logic [4:0]  byte_count_q;
	logic [15:0] crc_q;
	logic [7:0]  func_seen_q;
	logic [7:0]  crc_low_q;
	logic [15:0] voltage_q;
	logic [31:0] current_q;
	logic [31:0] power_q;
	logic [15:0] frequency_q;

	logic        flush;
	logic        take;
	logic [15:0] crc_base;
	logic [15:0] crc_next;
	logic        last;

	// A byte enters the frame if a frame is open or it matches the address.
	assign flush    = proc && (req_type == mmrp_pkg::REQ_FLUSH);
	assign take     = proc && (req_type == mmrp_pkg::REQ_BYTE)
	                  && ((byte_count_q != 5'd0) || (rx_byte == slave_addr));
	assign crc_base = (byte_count_q == 5'd0) ? mmrp_pkg::CRC_INIT : crc_q;
	assign last     = (byte_count_q == LAST_POS);

	mmrp_crc_byte u_crc (
		.crc_in  (crc_base),
		.data    (rx_byte),
		.crc_out (crc_next)
	);

	// Result of a completed frame; function code is checked before the CRC.
	always_comb begin
		res_vld       = take && last;
		res.status    = mmrp_pkg::ST_OK;
		res.voltage   = voltage_q;
		res.current   = current_q;
		res.power     = power_q;
		res.frequency = frequency_q;
		if (func_seen_q != func_code) begin
			res.status = mmrp_pkg::ST_BAD_FUNC;
		end else if (crc_q != {rx_byte, crc_low_q}) begin
			res.status = mmrp_pkg::ST_BAD_CRC;
		end
		if (res.status != mmrp_pkg::ST_OK) begin
			res.voltage   = '0;
			res.current   = '0;
			res.power     = '0;
			res.frequency = '0;
		end
	end

	// Frame state and field captures.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q <= '0;
			crc_q        <= mmrp_pkg::CRC_INIT;
			func_seen_q  <= '0;
			crc_low_q    <= '0;
			voltage_q    <= '0;
			current_q    <= '0;
			power_q      <= '0;
			frequency_q  <= '0;
		end else if (flush) begin
			byte_count_q <= '0;
		end else if (take) begin
			byte_count_q <= last ? 5'd0 : byte_count_q + 5'd1;
			if (byte_count_q < CRC_END) begin
				crc_q <= crc_next;
			end
			case (byte_count_q)
				5'd1:  func_seen_q         <= rx_byte;
				5'd3:  voltage_q[15:8]     <= rx_byte;
				5'd4:  voltage_q[7:0]      <= rx_byte;
				5'd5:  current_q[15:8]     <= rx_byte;
				5'd6:  current_q[7:0]      <= rx_byte;
				5'd7:  current_q[31:24]    <= rx_byte;
				5'd8:  current_q[23:16]    <= rx_byte;
				5'd9:  power_q[15:8]       <= rx_byte;
				5'd10: power_q[7:0]        <= rx_byte;
				5'd11: power_q[31:24]      <= rx_byte;
				5'd12: power_q[23:16]      <= rx_byte;
				5'd17: frequency_q[15:8]   <= rx_byte;
				5'd18: frequency_q[7:0]    <= rx_byte;
				5'd23: crc_low_q           <= rx_byte;
				default: ;
			endcase
		end
	end

	// The count never runs past the last byte position.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		byte_count_q <= LAST_POS)
		else $error("byte count beyond frame length");

	// A flush always closes the open frame.
	a_flush_closes: assert property (@(posedge clk) disable iff (!arst_n)
		flush |=> (byte_count_q == 5'd0))
		else $error("flush did not clear the byte count");

endmodule

`default_nettype wire

>>> rtl/core/modbus_meter_reply_parser.sv
// ----------------------------------------------------------------------------
// modbus_meter_reply_parser: Modbus RTU meter reply parser
// Parses 25-byte read-input-registers replies into status and measurements.
// ----------------------------------------------------------------------------
// Each request is one received byte (tuser 0) or a flush (tuser 1). Requests
// are taken one per clock unless the output stalls: a request is held in the
// input register, where the frame tracker updates its count, CRC and
// captures, and a reply that completes with its 25th byte is written to the
// output register in the same cycle. While a result waits for the sink, the
// input register can still take one request; after that the input stalls
// until the result is taken, whether or not the held request would complete
// a reply. Bytes that arrive with no frame open and do not match the slave
// address are dropped. Values are zero unless the status is ok.
`default_nettype none

module modbus_meter_reply_parser (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Configuration write port.
	input  wire logic        cfg_we,
	input  wire logic        cfg_idx,
	input  wire logic [7:0]  cfg_data,
	// Request stream.
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
	input  wire logic [0:0]  s_axis_tuser,   // [0] req_type
	// Result stream.
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [95:0]      m_axis_tdata,   // [15:0] voltage, [47:16] current,
	                                         // [79:48] power, [95:80] frequency
	output logic [1:0]       m_axis_tuser    // [1:0] status
);

	logic [7:0]        slave_addr_q;
	logic [7:0]        func_code_q;
	logic              vld_s1;
	logic              req_type_s1;
	logic [7:0]        rx_byte_s1;
	logic              out_vld_q;
	mmrp_pkg::result_t out_q;
	logic              out_free;
	logic              proc;
	logic              res_vld;
	mmrp_pkg::result_t res;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slave_addr_q <= mmrp_pkg::SLAVE_ADDR_RST;
			func_code_q  <= mmrp_pkg::FUNC_CODE_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				mmrp_pkg::CFG_SLAVE_ADDR: slave_addr_q <= cfg_data;
				mmrp_pkg::CFG_FUNC_CODE:  func_code_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Handshake: the input stage moves on whenever the output slot is free.
	assign out_free      = !out_vld_q || m_axis_tready;
	assign proc          = vld_s1 && out_free;
	assign s_axis_tready = !vld_s1 || out_free;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			vld_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			req_type_s1 <= s_axis_tuser[0];
			rx_byte_s1  <= s_axis_tdata;
		end
	end

	mmrp_frame u_frame (
		.clk        (clk),
		.arst_n     (arst_n),
		.proc       (proc),
		.req_type   (req_type_s1),
		.rx_byte    (rx_byte_s1),
		.slave_addr (slave_addr_q),
		.func_code  (func_code_q),
		.res_vld    (res_vld),
		.res        (res)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_free) begin
			out_vld_q <= proc && res_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (proc && res_vld) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tuser  = out_q.status;
	assign m_axis_tdata  = {out_q.frequency, out_q.power, out_q.current, out_q.voltage};

	// A new result only appears after a byte request was processed.
	a_result_from_byte: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_vld_q) |-> $past(proc && (req_type_s1 == mmrp_pkg::REQ_BYTE)))
		else $error("result without a processed byte request");

	// Error results carry no measurements.
	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && (out_q.status != mmrp_pkg::ST_OK)) |-> (m_axis_tdata == '0))
		else $error("error result with nonzero values");

endmodule

`default_nettype wire

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the Modbus meter reply parser
// Streams received bytes, flushes and noise into the parser, predicts each
// parsed reply with its own frame tracker and CRC, and checks every result
// field by field under random idling on both streams and a long output stall.
// ----------------------------------------------------------------------------

module tb_top;

	// Clock, reset and block ports.
	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic        cfg_idx = mmrp_pkg::CFG_SLAVE_ADDR;
	logic [7:0]  cfg_data = 8'h00;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] rx_byte
	logic [0:0]  s_axis_tuser = mmrp_pkg::REQ_BYTE; // [0] req_type
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [95:0] m_axis_tdata;           // [15:0] voltage, [47:16] current,
	                                     // [79:48] power, [95:80] frequency
	logic [1:0]  m_axis_tuser;           // [1:0] status

	// Frame tracker of the predictor and its register copies.
	logic [7:0]  addr_cfg = mmrp_pkg::SLAVE_ADDR_RST;
	logic [7:0]  func_cfg = mmrp_pkg::FUNC_CODE_RST;
	int unsigned frame_pos = 0;
	logic [15:0] crc_acc = mmrp_pkg::CRC_INIT;
	logic [7:0]  seen_func = 8'h00;
	logic [7:0]  seen_crc_lo = 8'h00;
	logic [15:0] volt_cap = 16'h0000;
	logic [31:0] curr_cap = 32'h0;
	logic [31:0] pwr_cap = 32'h0;
	logic [15:0] freq_cap = 16'h0000;

	// Replies still owed by the block, oldest first.
	mmrp_pkg::result_t replies_due[$];
	int unsigned replies_predicted = 0;
	int unsigned requests_used = 0;
	int unsigned mismatches = 0;

	// Idling controls shared by the test tasks and the stream processes.
	bit          src_gaps = 1'b0;
	bit          sink_gaps = 1'b0;
	int          stall_request = 0;

	// Frame under construction.
	logic [7:0]  frame_buf [mmrp_pkg::FRAME_LEN];

	modbus_meter_reply_parser dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_idx       (cfg_idx),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #6 clk = ~clk;

	// Gap lengths: mostly none or short, a few long.
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// One byte step of CRC-16/MODBUS, reflected polynomial.
	function automatic logic [15:0] crc_next(logic [15:0] crc, logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++)
			c = c[0] ? ((c >> 1) ^ mmrp_pkg::CRC_POLY) : (c >> 1);
		return c;
	endfunction

	// Advance the frame tracker by one accepted request and queue any reply.
	task automatic predict_request(input logic kind, input logic [7:0] b);
		mmrp_pkg::result_t r;
		int unsigned       pos;
		if (kind == mmrp_pkg::REQ_FLUSH) begin
			frame_pos = 0;
			requests_used++;
			return;
		end
		if (frame_pos == 0 && b != addr_cfg)
			return;
		requests_used++;
		pos = frame_pos;
		if (pos == 0)
			crc_acc = mmrp_pkg::CRC_INIT;
		if (pos < mmrp_pkg::CRC_SPAN)
			crc_acc = crc_next(crc_acc, b);
		case (pos)
			1: seen_func = b;
			3: volt_cap[15:8] = b;
			4: volt_cap[7:0] = b;
			5: curr_cap[15:8] = b;
			6: curr_cap[7:0] = b;
			7: curr_cap[31:24] = b;
			8: curr_cap[23:16] = b;
			9: pwr_cap[15:8] = b;
			10: pwr_cap[7:0] = b;
			11: pwr_cap[31:24] = b;
			12: pwr_cap[23:16] = b;
			17: freq_cap[15:8] = b;
			18: freq_cap[7:0] = b;
			23: seen_crc_lo = b;
			default: ;
		endcase
		if (pos + 1 < mmrp_pkg::FRAME_LEN) begin
			frame_pos = pos + 1;
			return;
		end
		frame_pos = 0;
		r = '0;
		if (seen_func != func_cfg) begin
			r.status = mmrp_pkg::ST_BAD_FUNC;
		end else if (crc_acc != {b, seen_crc_lo}) begin
			r.status = mmrp_pkg::ST_BAD_CRC;
		end else begin
			r.status = mmrp_pkg::ST_OK;
			r.voltage = volt_cap;
			r.current = curr_cap;
			r.power = pwr_cap;
			r.frequency = freq_cap;
		end
		replies_due.push_back(r);
		replies_predicted++;
	endtask

	// Print one mismatch line and count it.
	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		mismatches++;
		if (mismatches <= 50)
			$display("mismatch at %0t: %s got %h expected %h", $time, what, got, want);
	endtask

	// Offer one request and return once the block has taken it.
	task automatic send_request(input logic kind, input logic [7:0] value);
		int gap;
		gap = src_gaps ? gap_len() : 0;
		if (gap > 0) begin
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= value;
		s_axis_tuser <= kind;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		predict_request(kind, value);
	endtask

	// Stop offering, let owed replies drain and the input register settle.
	task automatic wait_idle();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (replies_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Register write; the block must be idle.
	task automatic write_reg(input logic idx, input logic [7:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= value;
		@(posedge clk);
		if (idx == mmrp_pkg::CFG_SLAVE_ADDR)
			addr_cfg = value;
		else
			func_cfg = value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Fill frame_buf with a reply carrying the given values; other bytes random.
	task automatic build_frame(input logic [7:0] addr, input logic [7:0] func,
			input logic [15:0] volt, input logic [31:0] curr, input logic [31:0] pwr,
			input logic [15:0] freq, input bit bad_crc);
		logic [15:0] crc;
		for (int i = 0; i < mmrp_pkg::FRAME_LEN; i++)
			frame_buf[i] = 8'($urandom_range(0, 255));
		frame_buf[0] = addr;
		frame_buf[1] = func;
		frame_buf[3] = volt[15:8];
		frame_buf[4] = volt[7:0];
		frame_buf[5] = curr[15:8];
		frame_buf[6] = curr[7:0];
		frame_buf[7] = curr[31:24];
		frame_buf[8] = curr[23:16];
		frame_buf[9] = pwr[15:8];
		frame_buf[10] = pwr[7:0];
		frame_buf[11] = pwr[31:24];
		frame_buf[12] = pwr[23:16];
		frame_buf[17] = freq[15:8];
		frame_buf[18] = freq[7:0];
		crc = mmrp_pkg::CRC_INIT;
		for (int i = 0; i < mmrp_pkg::CRC_SPAN; i++)
			crc = crc_next(crc, frame_buf[i]);
		if (bad_crc)
			crc = crc ^ (16'h0001 << $urandom_range(0, 15));
		frame_buf[23] = crc[7:0];
		frame_buf[24] = crc[15:8];
	endtask

	// Send the first count bytes of frame_buf.
	task automatic send_frame(input int count);
		for (int i = 0; i < count; i++)
			send_request(mmrp_pkg::REQ_BYTE, frame_buf[i]);
	endtask

	// Reset register values: noise, extremes of the values, every status,
	// flushes with and without an open frame.
	task automatic test_default_config();
		src_gaps = 1'b0;
		sink_gaps = 1'b0;
		send_request(mmrp_pkg::REQ_BYTE, 8'h00);
		send_request(mmrp_pkg::REQ_BYTE, 8'hFF);
		send_request(mmrp_pkg::REQ_FLUSH, 8'hFF);
		build_frame(addr_cfg, func_cfg, 16'h0000, 32'h0, 32'h0, 16'h0000, 1'b0);
		send_frame(mmrp_pkg::FRAME_LEN);
		build_frame(addr_cfg, func_cfg, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			16'hFFFF, 1'b0);
		send_frame(mmrp_pkg::FRAME_LEN);
		// Bytes equal to the address inside a frame are plain data.
		build_frame(addr_cfg, func_cfg, 16'h0101, 32'h1234_5678, 32'h8765_4321,
			16'h01F4, 1'b0);
		send_frame(mmrp_pkg::FRAME_LEN);
		build_frame(addr_cfg, func_cfg, 16'h0904, 32'h0000_1388, 32'h0001_0000,
			16'h01F4, 1'b1);
		send_frame(mmrp_pkg::FRAME_LEN);
		// Wrong function code wins over a bad CRC.
		build_frame(addr_cfg, 8'h03, 16'h0904, 32'h1, 32'h2, 16'h01F4, 1'b1);
		send_frame(mmrp_pkg::FRAME_LEN);
		// A partial frame dropped by a flush.
		build_frame(addr_cfg, func_cfg, 16'h1111, 32'h2222, 32'h3333, 16'h4444, 1'b0);
		send_frame(10);
		send_request(mmrp_pkg::REQ_FLUSH, 8'h00);
		src_gaps = 1'b1;
		sink_gaps = 1'b1;
		build_frame(addr_cfg, func_cfg, 16'hA5A5, 32'h5A5A_A5A5, 32'hC3C3_3C3C,
			16'h7E81, 1'b0);
		send_frame(mmrp_pkg::FRAME_LEN);
		wait_idle();
	endtask

	// Both registers at their extremes and back to a middle setting.
	task automatic test_register_extremes();
		write_reg(mmrp_pkg::CFG_SLAVE_ADDR, 8'h00);
		write_reg(mmrp_pkg::CFG_FUNC_CODE, 8'h00);
		send_request(mmrp_pkg::REQ_BYTE, 8'h01);
		build_frame(8'h00, 8'h00, 16'h1234, 32'hDEAD_BEEF, 32'h0BAD_F00D, 16'h0258, 1'b0);
		send_frame(mmrp_pkg::FRAME_LEN);
		build_frame(8'h00, 8'h04, 16'h1234, 32'h1, 32'h2, 16'h3, 1'b0);
		send_frame(mmrp_pkg::FRAME_LEN);
		wait_idle();
		write_reg(mmrp_pkg::CFG_SLAVE_ADDR, 8'hFF);
		write_reg(mmrp_pkg::CFG_FUNC_CODE, 8'hFF);
		send_request(mmrp_pkg::REQ_BYTE, 8'hFE);
		build_frame(8'hFF, 8'hFF, 16'hFFFF, 32'h8000_0001, 32'h7FFF_FFFE, 16'h0001, 1'b0);
		send_frame(mmrp_pkg::FRAME_LEN);
		build_frame(8'hFF, 8'hFF, 16'h0, 32'h0, 32'h0, 16'h0, 1'b1);
		send_frame(mmrp_pkg::FRAME_LEN);
		wait_idle();
		write_reg(mmrp_pkg::CFG_SLAVE_ADDR, 8'h5A);
		write_reg(mmrp_pkg::CFG_FUNC_CODE, 8'h04);
	endtask

	// Long output stall while the sender keeps offering whole frames.
	task automatic test_output_stall();
		src_gaps = 1'b0;
		sink_gaps = 1'b0;
		stall_request = 300;
		for (int n = 0; n < 4; n++) begin
			build_frame(addr_cfg, func_cfg, 16'($urandom), $urandom, $urandom,
				16'($urandom), n == 2);
			send_frame(mmrp_pkg::FRAME_LEN);
		end
		wait_idle();
	endtask

	// Mostly well-formed frames with random content, plus noise, truncated
	// frames, flushes and occasional register changes.
	task automatic test_random_traffic();
		int unsigned used_goal;
		int unsigned reply_goal;
		int          sel;
		int          kind;
		logic [7:0]  func;
		used_goal = requests_used + 440;
		reply_goal = replies_predicted + 12;
		while (requests_used < used_goal || replies_predicted < reply_goal) begin
			if ($urandom_range(0, 9) == 0)
				src_gaps = !src_gaps;
			if ($urandom_range(0, 9) == 0)
				sink_gaps = !sink_gaps;
			sel = $urandom_range(0, 99);
			if (sel < 4) begin
				wait_idle();
				case ($urandom_range(0, 3))
					0: write_reg(1'($urandom_range(0, 1)), 8'h00);
					1: write_reg(1'($urandom_range(0, 1)), 8'hFF);
					default: write_reg(1'($urandom_range(0, 1)),
						8'($urandom_range(0, 255)));
				endcase
			end else if (sel < 82) begin
				if (frame_pos != 0 && $urandom_range(0, 4) != 0)
					send_request(mmrp_pkg::REQ_FLUSH, 8'($urandom_range(0, 255)));
				kind = $urandom_range(0, 9);
				func = (kind == 9) ? (func_cfg ^ 8'($urandom_range(1, 255))) : func_cfg;
				build_frame(addr_cfg, func, 16'($urandom), $urandom, $urandom,
					16'($urandom), kind >= 6);
				if (sel < 70) begin
					send_frame(mmrp_pkg::FRAME_LEN);
				end else begin
					send_frame($urandom_range(1, mmrp_pkg::FRAME_LEN - 1));
					if ($urandom_range(0, 1) == 0)
						send_request(mmrp_pkg::REQ_FLUSH, 8'($urandom_range(0, 255)));
				end
			end else if (sel < 94) begin
				repeat ($urandom_range(1, 4))
					send_request(mmrp_pkg::REQ_BYTE, 8'($urandom_range(0, 255)));
			end else begin
				send_request(mmrp_pkg::REQ_FLUSH, 8'($urandom_range(0, 255)));
			end
		end
		wait_idle();
	endtask

	// Result sink: random stalls, stretches of steady readiness, and the long
	// hold-off when a test asks for one.
	initial begin
		int hold_left;
		int busy_left;
		int g;
		hold_left = 0;
		busy_left = 0;
		forever begin
			@(negedge clk);
			if (stall_request > 0) begin
				hold_left = stall_request;
				stall_request = 0;
			end
			if (hold_left > 0) begin
				m_axis_tready <= 1'b0;
				hold_left--;
			end else if (busy_left > 0) begin
				m_axis_tready <= 1'b0;
				busy_left--;
			end else if (!sink_gaps) begin
				m_axis_tready <= 1'b1;
			end else begin
				g = gap_len();
				m_axis_tready <= (g == 0);
				busy_left = (g > 0) ? g - 1 : 0;
			end
		end
	end

	// Check each accepted reply against the oldest prediction.
	always @(posedge clk) begin
		mmrp_pkg::result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (replies_due.size() == 0) begin
				report_mismatch("unexpected reply, status", 32'(m_axis_tuser), 32'h0);
			end else begin
				want = replies_due.pop_front();
				if (m_axis_tuser !== want.status)
					report_mismatch("status", 32'(m_axis_tuser), 32'(want.status));
				if (m_axis_tdata[15:0] !== want.voltage)
					report_mismatch("voltage", 32'(m_axis_tdata[15:0]), 32'(want.voltage));
				if (m_axis_tdata[47:16] !== want.current)
					report_mismatch("current", m_axis_tdata[47:16], want.current);
				if (m_axis_tdata[79:48] !== want.power)
					report_mismatch("power", m_axis_tdata[79:48], want.power);
				if (m_axis_tdata[95:80] !== want.frequency)
					report_mismatch("frequency", 32'(m_axis_tdata[95:80]),
						32'(want.frequency));
			end
		end
	end

	// Run limit.
	initial begin
		#5_000_000;
		$display("TB_ERROR");
		$finish;
	end

	// Test sequence.
	initial begin
		int waited;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);
		test_default_config();
		test_register_extremes();
		test_output_stall();
		test_random_traffic();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		waited = 0;
		while (replies_due.size() != 0 && waited < 2000) begin
			@(posedge clk);
			waited++;
		end
		if (replies_due.size() != 0)
			report_mismatch("replies never delivered", 32'(replies_due.size()), 32'h0);
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

>>> filelist.f
rtl/core/mmrp_pkg.sv
rtl/core/mmrp_crc_byte.sv
rtl/core/mmrp_frame.sv
rtl/core/modbus_meter_reply_parser.sv
tb/sv/tb_top.sv
